// ===== hdl/text_encoding_detector_top_assert.svh =====
// Assertion macros for the text encoding detector top level.
`ifndef TEXT_ENCODING_DETECTOR_TOP_ASSERT_SVH
`define TEXT_ENCODING_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TED_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_encoding_detector: check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_encoding_detector: check failed");

`endif

// ===== hdl/ted_pkg.sv =====
// Shared types, constants and the lead byte classifier for the encoding detector.
package ted_pkg;

  // Text type codes as they appear on the result channel
  typedef enum logic [1:0] {
    TYPE_ANSI = 2'd0,
    TYPE_UTF8 = 2'd1,
    TYPE_UCS2 = 2'd2,
    TYPE_RAW  = 2'd3
  } ted_text_t;

  // Byte order mark lengths
  localparam logic [1:0] SKIP_NONE = 2'd0;
  localparam logic [1:0] SKIP_UCS2 = 2'd2;
  localparam logic [1:0] SKIP_UTF8 = 2'd3;

  // Byte order mark bytes
  localparam logic [7:0] BOM_UCS2_0 = 8'hff;
  localparam logic [7:0] BOM_UCS2_1 = 8'hfe;
  localparam logic [7:0] BOM_UTF8_0 = 8'hef;
  localparam logic [7:0] BOM_UTF8_1 = 8'hbb;
  localparam logic [7:0] BOM_UTF8_2 = 8'hbf;

  // Continuation byte pattern 10xxxxxx
  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_MATCH = 8'h80;

  localparam int unsigned HEAD_DEPTH = 3;

  typedef logic [1:0] ted_pos_t;
  typedef logic [2:0] ted_pend_t;

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       empty_req;
  } ted_item_t;

  // One result item
  typedef struct packed {
    ted_text_t  text_type;
    logic [1:0] skip_bytes;
  } ted_result_t;

  // Continuation bytes expected after a lead byte
  function automatic ted_pend_t lead_length(input logic [7:0] b);
    ted_pend_t n;
    case (b) inside
      [8'h00:8'h7f]: n = 3'd0;
      [8'h80:8'hdf]: n = 3'd1;
      [8'he0:8'hef]: n = 3'd2;
      [8'hf0:8'hf7]: n = 3'd3;
      [8'hf8:8'hfb]: n = 3'd4;
      [8'hfc:8'hfd]: n = 3'd5;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/ted_in_if.sv =====
// Byte input channel: valid/ready handshake with one text byte per item.
interface ted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic       empty_req;

  modport source(output valid, output data_byte, output last, output empty_req,
                 input ready);
  modport sink(input valid, input data_byte, input last, input empty_req,
               output ready);
endinterface

// ===== hdl/ted_out_if.sv =====
// Result channel: valid/ready handshake with one detection result per item.
interface ted_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] text_type;
  logic [1:0] skip_bytes;

  modport source(output valid, output text_type, output skip_bytes, input ready);
  modport sink(input valid, input text_type, input skip_bytes, output ready);
endinterface

// ===== hdl/ted_core.sv =====
// Scan state of one text and the end-of-text decision.
module ted_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  ted_pkg::ted_item_t  item,
  output logic                produce,
  output ted_pkg::ted_result_t res
);

  ted_pkg::ted_pos_t  byte_position;
  logic [7:0]         head_bytes [ted_pkg::HEAD_DEPTH];
  ted_pkg::ted_pend_t pending;
  logic               sequence_failed;
  logic               nul_seen;

  ted_pkg::ted_pos_t  byte_position_next;
  logic [7:0]         head_next [ted_pkg::HEAD_DEPTH];
  ted_pkg::ted_pend_t pending_next;
  logic               sequence_failed_next;
  logic               nul_seen_next;

  logic               take;
  logic               is_cont;
  logic               ucs2_mark;
  logic               utf8_mark;

  assign take    = !item.empty_req;
  assign produce = item.empty_req || item.last;
  assign is_cont = (item.data_byte & ted_pkg::CONT_MASK) == ted_pkg::CONT_MATCH;

  // State after this item's byte (unchanged for an empty request)
  always_comb begin
    byte_position_next   = byte_position;
    head_next            = head_bytes;
    pending_next         = pending;
    sequence_failed_next = sequence_failed;
    nul_seen_next        = nul_seen;
    if (take) begin
      if (byte_position != 2'd3) begin
        head_next[byte_position] = item.data_byte;
        byte_position_next       = byte_position + 2'd1;
      end
      if (item.data_byte == 8'h00) begin
        nul_seen_next = 1'b1;
      end
      if (!sequence_failed) begin
        if (pending != 3'd0) begin
          if (!is_cont) begin
            // NUL cuts the sequence short without marking it bad
            if (item.data_byte != 8'h00) begin
              sequence_failed_next = 1'b1;
            end
            pending_next = 3'd0;
          end else begin
            pending_next = pending - 3'd1;
          end
        end else begin
          pending_next = ted_pkg::lead_length(item.data_byte);
        end
      end
    end
  end

  // End-of-text decision on the updated state
  assign ucs2_mark = (byte_position_next >= 2'd2) &&
                     (head_next[0] == ted_pkg::BOM_UCS2_0) &&
                     (head_next[1] == ted_pkg::BOM_UCS2_1);
  assign utf8_mark = (byte_position_next == 2'd3) &&
                     (head_next[0] == ted_pkg::BOM_UTF8_0) &&
                     (head_next[1] == ted_pkg::BOM_UTF8_1) &&
                     (head_next[2] == ted_pkg::BOM_UTF8_2);

  always_comb begin
    res.skip_bytes = ted_pkg::SKIP_NONE;
    if (byte_position_next == 2'd0) begin
      res.text_type = ted_pkg::TYPE_ANSI;
    end else if (ucs2_mark) begin
      res.text_type  = ted_pkg::TYPE_UCS2;
      res.skip_bytes = ted_pkg::SKIP_UCS2;
    end else if (utf8_mark) begin
      res.text_type  = ted_pkg::TYPE_UTF8;
      res.skip_bytes = ted_pkg::SKIP_UTF8;
    end else if (nul_seen_next) begin
      res.text_type = ted_pkg::TYPE_RAW;
    end else if (sequence_failed_next) begin
      res.text_type = ted_pkg::TYPE_ANSI;
    end else if (pending_next != 3'd0) begin
      res.text_type = ted_pkg::TYPE_RAW;
    end else begin
      res.text_type = ted_pkg::TYPE_UTF8;
    end
  end

  // Control state: cleared after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 2'd0;
      pending         <= 3'd0;
      sequence_failed <= 1'b0;
      nul_seen        <= 1'b0;
    end else if (go) begin
      if (produce) begin
        byte_position   <= 2'd0;
        pending         <= 3'd0;
        sequence_failed <= 1'b0;
        nul_seen        <= 1'b0;
      end else begin
        byte_position   <= byte_position_next;
        pending         <= pending_next;
        sequence_failed <= sequence_failed_next;
        nul_seen        <= nul_seen_next;
      end
    end
  end

  // Head bytes: only read at positions below byte_position, so no clear needed
  always_ff @(posedge clk) begin
    if (go) begin
      head_bytes <= head_next;
    end
  end

endmodule

// ===== hdl/text_encoding_detector_top.sv =====
// Text encoding detector: input register, scan core and result register.
// The result of a final item (last or empty_req) is held in the result register.
// Throughput: one item per cycle; the input register can advance while a result waits.
// A new result stalls only when the result register is still full and not being taken.
// Reset (rst, synchronous): empties both registers and clears the scan state.
module text_encoding_detector_top (
  input logic      clk,
  input logic      rst,
  ted_in_if.sink   bytes,
  ted_out_if.source result
);

  `include "text_encoding_detector_top_assert.svh"

  logic                 s1_valid;
  ted_pkg::ted_item_t   s1_item;
  logic                 s1_go;
  logic                 produce;
  ted_pkg::ted_result_t core_res;
  logic                 out_valid;
  ted_pkg::ted_result_t out_res;
  logic                 out_free;

  // Handshake control
  assign out_free    = !out_valid || result.ready;
  assign s1_go       = s1_valid && (!produce || out_free);
  assign bytes.ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      s1_item.data_byte <= bytes.data_byte;
      s1_item.last      <= bytes.last;
      s1_item.empty_req <= bytes.empty_req;
    end
  end

  ted_core u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (s1_go),
    .item    (s1_item),
    .produce (produce),
    .res     (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && produce) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && produce) begin
      out_res <= core_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.text_type  = out_res.text_type;
  assign result.skip_bytes = out_res.skip_bytes;

  // A result is never written over one that is still waiting
  `TED_ASSERT_NOW(a_no_overwrite, s1_go && produce, !out_valid || result.ready)
  // A consumed final item shows up as a result in the next cycle
  `TED_ASSERT_NEXT(a_result_follows, s1_go && produce, result.valid)
  // Back-pressure on the input only comes from a held input register
  `TED_ASSERT_NOW(a_ready_cause, !bytes.ready, s1_valid && produce && out_valid)

endmodule
